/* rtl/core/five_node_graphlet_classifier_defines.svh */
// assertion macros for the checker file
`ifndef FIVE_NODE_GRAPHLET_CLASSIFIER_DEFINES_SVH
`define FIVE_NODE_GRAPHLET_CLASSIFIER_DEFINES_SVH

// implication in the same cycle
`define FNGC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication in the next cycle
`define FNGC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/core/fngc_pkg.sv */
package fngc_pkg;

	localparam int NODES = 5;
	localparam int EDGES = 10;
	localparam int ID_W  = 5;

	typedef logic [2:0] deg_t;
	typedef logic [2:0] cnt_t;
	typedef logic [ID_W-1:0] id_t;

	// end points of each edge bit, from bit 0
	localparam logic [2:0] PAIR_LO [EDGES] = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd1,
		3'd1, 3'd1, 3'd2, 3'd2, 3'd3};
	localparam logic [2:0] PAIR_HI [EDGES] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd2,
		3'd3, 3'd4, 3'd3, 3'd4, 3'd4};

	// degree histogram plus the two neighbour tests
	typedef struct packed {
		cnt_t [4:0] cnt;
		logic       pend_nb2;
		logic       hub_all2;
	} hist_t;

endpackage

/* rtl/core/fngc_lookup.sv */
module fngc_lookup (
	input  fngc_pkg::hist_t hist,
	output fngc_pkg::id_t   graphlet_id,
	output logic            matched
);

	logic [11:0] key;

	// degree histogram of degrees one to four, sorted sequence in disguise
	assign key = {hist.cnt[1], hist.cnt[2], hist.cnt[3], hist.cnt[4]};

	// histogram to class table
	always_comb begin
		graphlet_id = '0;
		matched     = 1'b1;
		if (hist.cnt[0] != 3'd0) begin
			matched = 1'b0;
		end else begin
			case (key)
				{3'd2, 3'd3, 3'd0, 3'd0}: graphlet_id = 5'd8;
				{3'd3, 3'd1, 3'd1, 3'd0}: graphlet_id = 5'd1;
				{3'd4, 3'd0, 3'd0, 3'd1}: graphlet_id = 5'd0;
				{3'd2, 3'd1, 3'd2, 3'd0}: graphlet_id = 5'd4;
				{3'd2, 3'd2, 3'd0, 3'd1}: graphlet_id = 5'd2;
				{3'd0, 3'd5, 3'd0, 3'd0}: graphlet_id = 5'd11;
				{3'd1, 3'd2, 3'd1, 3'd1}: graphlet_id = 5'd5;
				{3'd0, 3'd4, 3'd0, 3'd1}: graphlet_id = 5'd10;
				{3'd1, 3'd1, 3'd3, 3'd0}: graphlet_id = 5'd14;
				{3'd0, 3'd3, 3'd0, 3'd2}: graphlet_id = 5'd7;
				{3'd1, 3'd0, 3'd3, 3'd1}: graphlet_id = 5'd15;
				{3'd0, 3'd2, 3'd2, 3'd1}: graphlet_id = 5'd13;
				{3'd0, 3'd1, 3'd4, 3'd0}: graphlet_id = 5'd17;
				{3'd0, 3'd1, 3'd2, 3'd2}: graphlet_id = 5'd16;
				{3'd0, 3'd0, 3'd4, 3'd1}: graphlet_id = 5'd18;
				{3'd0, 3'd0, 3'd2, 3'd3}: graphlet_id = 5'd19;
				{3'd0, 3'd0, 3'd0, 3'd5}: graphlet_id = 5'd20;
				// pendant vertex split
				{3'd1, 3'd3, 3'd1, 3'd0}: graphlet_id = hist.pend_nb2 ? 5'd9 : 5'd3;
				// degree-three vertex split
				{3'd0, 3'd3, 3'd2, 3'd0}: graphlet_id = hist.hub_all2 ? 5'd6 : 5'd12;
				default: matched = 1'b0;
			endcase
		end
	end

endmodule

/* rtl/core/five_node_graphlet_classifier.sv */
// five-node graphlet classifier
// input channel: edge_valid / edge_stall carry one request, edge_bits, the
//   ten adjacency bits of a 5-vertex graph (pairs 01,02,03,04,12,13,14,23,24,34
//   from bit 0)
// output channel: class_valid / class_stall carry graphlet_id and matched;
//   matched low means the degree sequence names no class and the id is 0
// a request is taken on a rising edge with valid high and stall low
// throughput: one request per cycle, sustained while class_stall stays low
// stages: stage 1 registers the vertex degrees, stage 2 the degree histogram
//   and neighbour tests, stage 3 the looked-up class, which drives class_valid,
//   graphlet_id and matched
// reset: arst_n clears every stage valid at once; no requests are lost
//   beyond those in flight, which are dropped
// receiver stall: the output holds its result; empty stages behind it still
//   fill, and edge_stall rises only once all three stages are full
module five_node_graphlet_classifier (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                edge_valid,
	output logic                edge_stall,
	input  logic [9:0]          edge_bits,
	output logic                class_valid,
	input  logic                class_stall,
	output logic [4:0]          graphlet_id,
	output logic                matched
);

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	logic [9:0]         bits_s1;
	fngc_pkg::deg_t     deg_s1 [fngc_pkg::NODES];
	fngc_pkg::deg_t     deg_c  [fngc_pkg::NODES];
	fngc_pkg::hist_t    hist_c;
	fngc_pkg::hist_t    hist_s2;
	fngc_pkg::id_t      id_c;
	logic               matched_c;
	fngc_pkg::id_t      id_s3;
	logic               matched_s3;
	logic               adj [fngc_pkg::NODES][fngc_pkg::NODES];

	// stage advance, bubbles collapse
	assign rdy3 = !v_s3 || !class_stall;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign edge_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= edge_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// vertex degrees
	always_comb begin
		for (int i = 0; i < fngc_pkg::NODES; i++) deg_c[i] = '0;
		for (int k = 0; k < fngc_pkg::EDGES; k++) begin
			deg_c[fngc_pkg::PAIR_LO[k]] = deg_c[fngc_pkg::PAIR_LO[k]] + {2'b00, edge_bits[k]};
			deg_c[fngc_pkg::PAIR_HI[k]] = deg_c[fngc_pkg::PAIR_HI[k]] + {2'b00, edge_bits[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && edge_valid) begin
			bits_s1 <= edge_bits;
			deg_s1  <= deg_c;
		end
	end

	// adjacency matrix from the stage 1 edge bits
	always_comb begin
		for (int u = 0; u < fngc_pkg::NODES; u++)
			for (int v = 0; v < fngc_pkg::NODES; v++) adj[u][v] = 1'b0;
		for (int k = 0; k < fngc_pkg::EDGES; k++) begin
			adj[fngc_pkg::PAIR_LO[k]][fngc_pkg::PAIR_HI[k]] = bits_s1[k];
			adj[fngc_pkg::PAIR_HI[k]][fngc_pkg::PAIR_LO[k]] = bits_s1[k];
		end
	end

	// degree histogram and neighbour tests
	always_comb begin
		logic pend_found;
		logic hub_found;
		hist_c     = '0;
		pend_found = 1'b0;
		hub_found  = 1'b0;
		hist_c.hub_all2 = 1'b1;
		for (int i = 0; i < fngc_pkg::NODES; i++)
			hist_c.cnt[deg_s1[i]] = hist_c.cnt[deg_s1[i]] + 3'd1;
		// lowest-numbered pendant vertex: is its neighbour of degree two
		for (int i = 0; i < fngc_pkg::NODES; i++) begin
			if (!pend_found && deg_s1[i] == 3'd1) begin
				pend_found = 1'b1;
				for (int j = 0; j < fngc_pkg::NODES; j++)
					if (j != i && adj[i][j] && deg_s1[j] == 3'd2) hist_c.pend_nb2 = 1'b1;
			end
		end
		// lowest-numbered degree-three vertex: are all its neighbours of degree two
		for (int i = 0; i < fngc_pkg::NODES; i++) begin
			if (!hub_found && deg_s1[i] == 3'd3) begin
				hub_found = 1'b1;
				for (int j = 0; j < fngc_pkg::NODES; j++)
					if (j != i && adj[i][j] && deg_s1[j] != 3'd2) hist_c.hub_all2 = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) hist_s2 <= hist_c;
	end

	// class lookup
	fngc_lookup u_lookup (
		.hist        (hist_s2),
		.graphlet_id (id_c),
		.matched     (matched_c)
	);

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			id_s3      <= id_c;
			matched_s3 <= matched_c;
		end
	end

	assign class_valid = v_s3;
	assign graphlet_id = id_s3;
	assign matched     = matched_s3;

endmodule

/* rtl/core/fngc_checker.sv */
`include "five_node_graphlet_classifier_defines.svh"

module fngc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       edge_valid,
	input logic       edge_stall,
	input logic       class_valid,
	input logic       class_stall,
	input logic [4:0] graphlet_id,
	input logic       matched
);

	logic edge_req;
	assign edge_req = edge_valid && !edge_stall;

	// a stalled result stays offered
	`FNGC_ASSERT_NEXT(a_out_hold, class_valid && class_stall, class_valid)

	// a stalled result keeps its payload
	`FNGC_ASSERT_NEXT(a_out_stable, class_valid && class_stall, $stable(graphlet_id) && $stable(matched))

	// no match always reads as class zero
	`FNGC_ASSERT_NOW(a_nomatch_zero, class_valid && !matched, graphlet_id == 5'd0)

	// with the receiver free, an accepted request comes out through the pipeline stages
	`FNGC_ASSERT_NEXT(a_latency, edge_req ##1 !class_stall ##1 !class_stall, class_valid)

endmodule

bind five_node_graphlet_classifier fngc_checker u_fngc_checker (.*);

/* tb/tb_five_node_graphlet_classifier.sv */
`timescale 1ns / 1ps

module tb_five_node_graphlet_classifier;

	localparam int RANDOM_GRAPHS = 950;
	localparam int CYCLE_LIMIT   = 100000;
	localparam int DRAIN_CYCLES  = 20;

	// end points of each adjacency bit, from bit 0
	localparam logic [2:0] END_A [10] = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd1,
		3'd1, 3'd1, 3'd2, 3'd2, 3'd3};
	localparam logic [2:0] END_B [10] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd2,
		3'd3, 3'd4, 3'd3, 3'd4, 3'd4};

	// sorted degree sequences that need a neighbour test
	localparam logic [14:0] PENDANT_SEQ = {3'd1, 3'd2, 3'd2, 3'd2, 3'd3};
	localparam logic [14:0] TWIN_HUB_SEQ = {3'd2, 3'd2, 3'd2, 3'd3, 3'd3};

	typedef struct {
		logic [9:0]    graph;
		fngc_pkg::id_t id;
		logic          matched;
	} graph_class_t;

	// expected classes of accepted graphs, oldest first
	class class_scoreboard;
		graph_class_t want [$];
		int unsigned  errors;
		int unsigned  checked;
		int unsigned  unmatched;
		bit           seen [21];

		function bit is_adjacent(logic [9:0] graph, int unsigned u, int unsigned v);
			for (int k = 0; k < 10; k++) begin
				if ((END_A[k] == u && END_B[k] == v) || (END_A[k] == v && END_B[k] == u))
					return graph[k];
			end
			return 1'b0;
		endfunction

		function graph_class_t classify_graph(logic [9:0] graph);
			logic [2:0]   deg [5];
			logic [2:0]   srt [5];
			logic [2:0]   tmp;
			logic [14:0]  seq;
			int unsigned  pend, nb, hub;
			bit           all_two;
			graph_class_t r;
			r.graph = graph;
			r.id = '0;
			r.matched = 1'b1;
			foreach (deg[i]) deg[i] = 3'd0;
			for (int k = 0; k < 10; k++) begin
				if (graph[k]) begin
					deg[END_A[k]] = deg[END_A[k]] + 3'd1;
					deg[END_B[k]] = deg[END_B[k]] + 3'd1;
				end
			end
			// ascending degree sequence
			foreach (deg[i]) srt[i] = deg[i];
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4 - i; j++) begin
					if (srt[j] > srt[j+1]) begin
						tmp = srt[j];
						srt[j] = srt[j+1];
						srt[j+1] = tmp;
					end
				end
			end
			seq = {srt[0], srt[1], srt[2], srt[3], srt[4]};
			if (seq == PENDANT_SEQ) begin
				// lowest degree-one vertex, then its only neighbour
				pend = 0;
				for (int i = 4; i >= 0; i--) if (deg[i] == 3'd1) pend = i;
				nb = pend;
				for (int j = 4; j >= 0; j--)
					if (j != pend && is_adjacent(graph, pend, j)) nb = j;
				r.id = (deg[nb] == 3'd2) ? 5'd9 : 5'd3;
			end else if (seq == TWIN_HUB_SEQ) begin
				// lowest degree-three vertex, then whether all its neighbours have degree two
				hub = 0;
				for (int i = 4; i >= 0; i--) if (deg[i] == 3'd3) hub = i;
				all_two = 1'b1;
				for (int j = 0; j < 5; j++)
					if (j != hub && is_adjacent(graph, hub, j) && deg[j] != 3'd2)
						all_two = 1'b0;
				r.id = all_two ? 5'd6 : 5'd12;
			end else begin
				case (seq)
					{3'd1, 3'd1, 3'd2, 3'd2, 3'd2}: r.id = 5'd8;
					{3'd1, 3'd1, 3'd1, 3'd2, 3'd3}: r.id = 5'd1;
					{3'd1, 3'd1, 3'd1, 3'd1, 3'd4}: r.id = 5'd0;
					{3'd1, 3'd1, 3'd2, 3'd3, 3'd3}: r.id = 5'd4;
					{3'd1, 3'd1, 3'd2, 3'd2, 3'd4}: r.id = 5'd2;
					{3'd2, 3'd2, 3'd2, 3'd2, 3'd2}: r.id = 5'd11;
					{3'd1, 3'd2, 3'd2, 3'd3, 3'd4}: r.id = 5'd5;
					{3'd2, 3'd2, 3'd2, 3'd2, 3'd4}: r.id = 5'd10;
					{3'd1, 3'd2, 3'd3, 3'd3, 3'd3}: r.id = 5'd14;
					{3'd2, 3'd2, 3'd2, 3'd4, 3'd4}: r.id = 5'd7;
					{3'd1, 3'd3, 3'd3, 3'd3, 3'd4}: r.id = 5'd15;
					{3'd2, 3'd2, 3'd3, 3'd3, 3'd4}: r.id = 5'd13;
					{3'd2, 3'd3, 3'd3, 3'd3, 3'd3}: r.id = 5'd17;
					{3'd2, 3'd3, 3'd3, 3'd4, 3'd4}: r.id = 5'd16;
					{3'd3, 3'd3, 3'd3, 3'd3, 3'd4}: r.id = 5'd18;
					{3'd3, 3'd3, 3'd4, 3'd4, 3'd4}: r.id = 5'd19;
					{3'd4, 3'd4, 3'd4, 3'd4, 3'd4}: r.id = 5'd20;
					default: r.matched = 1'b0;
				endcase
			end
			return r;
		endfunction

		function void note_graph(logic [9:0] graph);
			want = {want, classify_graph(graph)};
		endfunction

		function void check_class(fngc_pkg::id_t id, logic matched);
			graph_class_t e;
			if (want.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: id %0d matched %b", id, matched);
				return;
			end
			e = want.pop_front();
			checked++;
			if (e.matched) seen[e.id] = 1'b1;
			else unmatched++;
			if (id !== e.id || matched !== e.matched) begin
				errors++;
				if (errors <= 10)
					$display("graph %03h: expected id %0d matched %b, got id %0d matched %b",
						e.graph, e.id, e.matched, id, matched);
			end
		endfunction

		function int unsigned pending();
			return want.size();
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          edge_valid = 1'b0;
	logic          edge_stall;
	logic [9:0]    edge_bits = '0;
	logic          class_valid;
	logic          class_stall = 1'b0;
	fngc_pkg::id_t graphlet_id;
	logic          matched;

	class_scoreboard sb = new();
	bit              calm = 1'b0;
	int unsigned     sent = 0;

	five_node_graphlet_classifier dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.edge_valid  (edge_valid),
		.edge_stall  (edge_stall),
		.edge_bits   (edge_bits),
		.class_valid (class_valid),
		.class_stall (class_stall),
		.graphlet_id (graphlet_id),
		.matched     (matched)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// random idle decision shared by both sides
	function automatic bit roll_idle();
		return !calm && ($urandom_range(99) < 12);
	endfunction

	// mostly uniform graphs, with sparse and near-complete ones mixed in
	function automatic logic [9:0] pick_graph();
		logic [9:0] g;
		int unsigned mode;
		mode = $urandom_range(9);
		if (mode < 6) begin
			g = 10'($urandom_range(1023));
		end else if (mode < 8) begin
			g = '0;
			repeat ($urandom_range(5, 4)) g[$urandom_range(9)] = 1'b1;
		end else begin
			g = '1;
			repeat ($urandom_range(3, 1)) g[$urandom_range(9)] = 1'b0;
		end
		return g;
	endfunction

	// one request, with random idle cycles ahead of it
	task automatic send_graph(input logic [9:0] graph);
		while (roll_idle()) begin
			edge_valid <= 1'b0;
			@(posedge clk);
		end
		edge_valid <= 1'b1;
		edge_bits <= graph;
		do @(posedge clk); while (edge_stall !== 1'b0);
		sb.note_graph(graph);
		sent++;
	endtask

	// receiver: check accepted results, stall at random
	always @(posedge clk) begin
		if (arst_n && class_valid === 1'b1 && class_stall == 1'b0)
			sb.check_class(graphlet_id, matched);
		class_stall <= roll_idle();
	end

	// hang guard
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout with %0d results outstanding", sb.pending());
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [9:0] directed [$];
		int         classes;
		// empty, complete, star, path, triangle plus edge, cycle, both
		// pendant shapes, both twin-hub shapes, lone triangle, K5 less one edge
		directed = '{10'h000, 10'h3FF, 10'h00F, 10'h291, 10'h213, 10'h299,
			10'h293, 10'h09D, 10'h07E, 10'h29B, 10'h013, 10'h3FE};
		// each edge on its own
		for (int k = 0; k < 10; k++) directed = {directed, 10'(1) << k};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) send_graph(directed[i]);
		for (int n = 0; n < RANDOM_GRAPHS; n++) begin
			calm = (n >= 300 && n < 500);
			send_graph(pick_graph());
		end
		calm = 1'b0;
		edge_valid <= 1'b0;

		// drain, then watch for stray results
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		classes = 0;
		foreach (sb.seen[i]) if (sb.seen[i]) classes++;
		$display("%0d graphs sent, %0d results checked, %0d mismatches", sent, sb.checked,
			sb.errors);
		$display("%0d of 21 graphlet classes hit, %0d graphs with no class", classes,
			sb.unmatched);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
